// ===== rtl/core/prc_pkg.sv =====
// Shared types and constants for the rectangle polygon clipper.
package prc_pkg;

   localparam int StkDepth = 8;
   localparam int StkPtrW  = 3;

   typedef logic [2:0] lvl_type;
   localparam lvl_type LvlOut = 3'd4;  // past the last edge stage: a final vertex

   typedef enum logic [1:0] {
      EDGE_LEFT   = 2'd0,
      EDGE_RIGHT  = 2'd1,
      EDGE_TOP    = 2'd2,
      EDGE_BOTTOM = 2'd3
   } edge_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_TASK,
      ST_CLOSE,
      ST_MUL,
      ST_DIV,
      ST_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic pop;
      logic eval;
      logic pick_close;
      logic close;
      logic mul;
      logic div_start;
      logic push_cross;
      logic emit;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic stack_empty;
      logic top_is_out;
      logic need_cross;
      logic poly_end;
      logic close_done;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/polygon_rect_clipper.sv =====
// Top level of the rectangle polygon clipper.
//
// Vertices of a closed polygon enter on the req_ stream, one item each,
// with req_tlast on the final vertex. Each vertex is clipped in turn
// against the left, right, top and bottom window bounds (inclusive),
// written beforehand through the csr_ port (index 0..3 = left, right,
// top, bottom). Clipped vertices leave on the rsp_ stream; rsp_tlast marks
// the last vertex of the clipped polygon, and a polygon wholly outside
// gives a single item with rsp_tuser (all clipped) set and zero coordinates.
// One clipped vertex is held back so the final one can carry rsp_tlast.
// An item is taken one at a time: req_tready is high only while the
// sequencer is idle. Each stage visit is a pop, then an evaluate; each
// crossing point adds a multiply, a divider start, COORD_WIDTH steps of
// the bit-serial divider and a push. The closing vertex adds four stage
// closes and a final flush. The result register frees the sequencer
// while a finished item waits; a stalled rsp_tready holds the sequencer
// at its next emit or final flush while that register is full.
// Synchronous reset clears the window to zero and drops any polygon in
// progress.
module polygon_rect_clipper #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]      req_tdata,   // vertex_x, vertex_y, zero pad
   input  logic                                    req_tlast,   // vertex_last
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((2*COORD_WIDTH+7)/8)*8-1:0]      rsp_tdata,   // out_x, out_y, zero pad
   output logic                                    rsp_tlast,   // out_last
   output logic                                    rsp_tuser,   // all_clipped
   input  logic                                    csr_wr_en,
   input  logic [1:0]                              csr_index,
   input  logic [COORD_WIDTH-1:0]                  csr_wdata
);
   import prc_pkg::*;

   localparam int DataW = ((2 * COORD_WIDTH + 7) / 8) * 8;

   cmd_type                cmd;
   status_type             status;
   logic [COORD_WIDTH-1:0] out_x, out_y;

   prc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   prc_dp #(.W(COORD_WIDTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_x      (req_tdata[COORD_WIDTH-1:0]),
      .in_y      (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .in_last   (req_tlast),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_x     (out_x),
      .rsp_y     (out_y),
      .rsp_last  (rsp_tlast),
      .rsp_empty (rsp_tuser)
   );

   assign rsp_tdata = DataW'({out_y, out_x});

endmodule

// ===== rtl/core/prc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module prc_div #(
   parameter int W = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [2*W-1:0] dividend,  // must satisfy dividend < divisor * 2**W
   input  logic [W-1:0]   divisor,
   output logic           busy,
   output logic [W-1:0]   quotient
);
   localparam int CW = $clog2(W);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  lo_ff, lo_in;
   logic [W-1:0]  dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic [W:0]    trial;
   logic [W:0]    diff;
   logic          ge;

   always_comb begin
      trial  = {rem_ff, lo_ff[W-1]};
      diff   = trial - {1'b0, dvs_ff};
      ge     = trial >= {1'b0, dvs_ff};
      rem_in = ge ? diff[W-1:0] : trial[W-1:0];
      lo_in  = {lo_ff[W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[2*W-1:W];
         lo_ff  <= dividend[W-1:0];
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         lo_ff  <= lo_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = lo_ff;

endmodule

// ===== rtl/core/prc_dp.sv =====
// Clipper datapath: window registers, edge stage state, work stack, crossing math, output.
module prc_dp #(
   parameter int W = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  prc_pkg::cmd_type    cmd,
   output prc_pkg::status_type status,
   input  logic [W-1:0]        in_x,
   input  logic [W-1:0]        in_y,
   input  logic                in_last,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [W-1:0]        csr_wdata,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [W-1:0]        rsp_x,
   output logic [W-1:0]        rsp_y,
   output logic                rsp_last,
   output logic                rsp_empty
);
   import prc_pkg::*;

   function automatic logic pt_in(input logic [1:0] k, input logic signed [W-1:0] x,
                                  input logic signed [W-1:0] y, input logic signed [W-1:0] l,
                                  input logic signed [W-1:0] r, input logic signed [W-1:0] t,
                                  input logic signed [W-1:0] b);
      logic res;
      case (k)
         EDGE_LEFT:   res = x >= l;
         EDGE_RIGHT:  res = x <= r;
         EDGE_TOP:    res = y >= t;
         default:     res = y <= b;
      endcase
      return res;
   endfunction

   // window
   logic signed [W-1:0] win_l_ff, win_r_ff, win_t_ff, win_b_ff;

   // edge stages
   logic signed [W-1:0] first_x_ff [4];
   logic signed [W-1:0] first_y_ff [4];
   logic signed [W-1:0] prev_x_ff  [4];
   logic signed [W-1:0] prev_y_ff  [4];
   logic [3:0]          started_ff;

   // work stack
   logic [W-1:0]        stk_x_ff [StkDepth];
   logic [W-1:0]        stk_y_ff [StkDepth];
   lvl_type             stk_l_ff [StkDepth];
   logic [StkPtrW:0]    sp_ff;
   logic [StkPtrW:0]    sp_m1;
   logic                push_en;
   logic [W-1:0]        push_x, push_y;
   lvl_type             push_l;

   // current task
   logic signed [W-1:0] cur_x_ff, cur_y_ff;
   lvl_type             cur_l_ff;
   logic                close_mode_ff;
   lvl_type             close_k_ff;
   logic                last_ff;

   // crossing operands
   logic signed [W-1:0] base_ff, bnd_ff;
   logic                horiz_ff, neg_ff;
   logic [W-1:0]        ua_ff, un_ff, ud_ff;
   lvl_type             cross_l_ff;
   logic [2*W-1:0]      prod_ff;

   // held final vertex and output register
   logic [W-1:0]        held_x_ff, held_y_ff;
   logic                held_valid_ff;
   logic                out_valid_ff;
   logic [W-1:0]        out_x_ff, out_y_ff;
   logic                out_last_ff, out_empty_ff;

   logic [1:0]          k;
   logic signed [W-1:0] qx, qy, sx, sy, bnd;
   logic                horiz, q_in, s_in;
   logic signed [W:0]   a_v, n_v, d_v;
   logic [W:0]          a_m, n_m, d_m;
   logic [W-1:0]        quo;
   logic                div_busy;
   logic [W:0]          q_s, sum;
   logic [W-1:0]        cross_x, cross_y;
   logic                out_free;

   assign k     = cur_l_ff[1:0];
   assign qx    = close_mode_ff ? first_x_ff[k] : cur_x_ff;
   assign qy    = close_mode_ff ? first_y_ff[k] : cur_y_ff;
   assign sx    = prev_x_ff[k];
   assign sy    = prev_y_ff[k];
   assign horiz = (k == EDGE_LEFT) || (k == EDGE_RIGHT);
   assign q_in  = pt_in(k, qx, qy, win_l_ff, win_r_ff, win_t_ff, win_b_ff);
   assign s_in  = pt_in(k, sx, sy, win_l_ff, win_r_ff, win_t_ff, win_b_ff);

   always_comb begin
      unique case (edge_type'(k))
         EDGE_LEFT:   bnd = win_l_ff;
         EDGE_RIGHT:  bnd = win_r_ff;
         EDGE_TOP:    bnd = win_t_ff;
         EDGE_BOTTOM: bnd = win_b_ff;
      endcase
      if (horiz) begin
         a_v = {qy[W-1], qy} - {sy[W-1], sy};
         n_v = {bnd[W-1], bnd} - {sx[W-1], sx};
         d_v = {qx[W-1], qx} - {sx[W-1], sx};
      end else begin
         a_v = {qx[W-1], qx} - {sx[W-1], sx};
         n_v = {bnd[W-1], bnd} - {sy[W-1], sy};
         d_v = {qy[W-1], qy} - {sy[W-1], sy};
      end
      a_m = a_v[W] ? -a_v : a_v;
      n_m = n_v[W] ? -n_v : n_v;
      d_m = d_v[W] ? -d_v : d_v;
   end

   // crossing point from the divided result
   always_comb begin
      q_s = neg_ff ? -{1'b0, quo} : {1'b0, quo};
      sum = {base_ff[W-1], base_ff} + q_s;
      cross_x = horiz_ff ? bnd_ff : sum[W-1:0];
      cross_y = horiz_ff ? sum[W-1:0] : bnd_ff;
   end

   // stack push selection
   always_comb begin
      push_en = 1'b0;
      push_x  = in_x;
      push_y  = in_y;
      push_l  = '0;
      if (cmd.accept) begin
         push_en = 1'b1;
      end else if (cmd.eval) begin
         push_en = q_in;
         push_x  = cur_x_ff;
         push_y  = cur_y_ff;
         push_l  = cur_l_ff + 1'b1;
      end else if (cmd.push_cross) begin
         push_en = 1'b1;
         push_x  = cross_x;
         push_y  = cross_y;
         push_l  = cross_l_ff;
      end
   end

   assign sp_m1 = sp_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else if (push_en) begin
         sp_ff <= sp_ff + 1'b1;
      end else if (cmd.pop) begin
         sp_ff <= sp_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         stk_x_ff[sp_ff[StkPtrW-1:0]] <= push_x;
         stk_y_ff[sp_ff[StkPtrW-1:0]] <= push_y;
         stk_l_ff[sp_ff[StkPtrW-1:0]] <= push_l;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_l_ff <= '0;
         win_r_ff <= '0;
         win_t_ff <= '0;
         win_b_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (edge_type'(csr_index))
            EDGE_LEFT:   win_l_ff <= csr_wdata;
            EDGE_RIGHT:  win_r_ff <= csr_wdata;
            EDGE_TOP:    win_t_ff <= csr_wdata;
            EDGE_BOTTOM: win_b_ff <= csr_wdata;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= '0;
         close_mode_ff <= 1'b0;
         close_k_ff    <= '0;
         last_ff       <= 1'b0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.accept) begin
            last_ff    <= in_last;
            close_k_ff <= '0;
         end
         if (cmd.pop) close_mode_ff <= 1'b0;
         if (cmd.pick_close) close_mode_ff <= 1'b1;
         if (cmd.eval) started_ff[k] <= 1'b1;
         if (cmd.close) begin
            started_ff[k] <= 1'b0;
            close_k_ff    <= close_k_ff + 1'b1;
         end
         if (cmd.emit) held_valid_ff <= 1'b1;
         if (cmd.finish) held_valid_ff <= 1'b0;
         if ((cmd.emit && held_valid_ff) || cmd.finish) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         cur_x_ff <= stk_x_ff[sp_m1[StkPtrW-1:0]];
         cur_y_ff <= stk_y_ff[sp_m1[StkPtrW-1:0]];
         cur_l_ff <= stk_l_ff[sp_m1[StkPtrW-1:0]];
      end else if (cmd.pick_close) begin
         cur_l_ff <= close_k_ff;
      end
      if (cmd.eval) begin
         if (!started_ff[k]) begin
            first_x_ff[k] <= cur_x_ff;
            first_y_ff[k] <= cur_y_ff;
         end
         prev_x_ff[k] <= cur_x_ff;
         prev_y_ff[k] <= cur_y_ff;
      end
      if (cmd.eval || cmd.close) begin
         base_ff    <= horiz ? sy : sx;
         bnd_ff     <= bnd;
         horiz_ff   <= horiz;
         neg_ff     <= a_v[W] ^ n_v[W] ^ d_v[W];
         ua_ff      <= a_m[W-1:0];
         un_ff      <= n_m[W-1:0];
         ud_ff      <= d_m[W-1:0];
         cross_l_ff <= cur_l_ff + 1'b1;
      end
      if (cmd.mul) prod_ff <= ua_ff * un_ff;
      if (cmd.emit) begin
         held_x_ff <= cur_x_ff;
         held_y_ff <= cur_y_ff;
      end
      if (cmd.emit) begin
         out_x_ff     <= held_x_ff;
         out_y_ff     <= held_y_ff;
         out_last_ff  <= 1'b0;
         out_empty_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_x_ff     <= held_valid_ff ? held_x_ff : '0;
         out_y_ff     <= held_valid_ff ? held_y_ff : '0;
         out_last_ff  <= 1'b1;
         out_empty_ff <= !held_valid_ff;
      end
   end

   prc_div #(.W(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (ud_ff),
      .busy     (div_busy),
      .quotient (quo)
   );

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      status.stack_empty = sp_ff == '0;
      status.top_is_out  = cur_l_ff == LvlOut;
      status.need_cross  = started_ff[k] && (s_in != q_in);
      status.poly_end    = last_ff;
      status.close_done  = close_k_ff == LvlOut;
      status.div_busy    = div_busy;
      status.out_free    = out_free;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_x     = out_x_ff;
   assign rsp_y     = out_y_ff;
   assign rsp_last  = out_last_ff;
   assign rsp_empty = out_empty_ff;

`ifndef SYNTHESIS
   a_stk_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_en && sp_ff == (StkPtrW + 1)'(StkDepth)))
      else $error("work stack overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> sp_ff != '0)
      else $error("pop from empty work stack");
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !held_valid_ff && out_valid_ff)
      else $error("finish did not flush held vertex");
   a_close_forgets: assert property (@(posedge clock) disable iff (reset)
      cmd.close |=> !started_ff[$past(k)])
      else $error("stage still started after close");
`endif

endmodule

// ===== rtl/core/prc_ctrl.sv =====
// Clipper sequencer: walks the work stack, stage closes and the crossing divide.
module prc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  prc_pkg::status_type status,
   output prc_pkg::cmd_type    cmd
);
   import prc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            priority if (!status.stack_empty) begin
               cmd.pop  = 1'b1;
               state_in = ST_TASK;
            end else if (!status.poly_end) begin
               state_in = ST_IDLE;
            end else if (!status.close_done) begin
               cmd.pick_close = 1'b1;
               state_in       = ST_CLOSE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_TASK: begin
            if (status.top_is_out) begin
               if (status.out_free) begin
                  cmd.emit = 1'b1;
                  state_in = ST_RUN;
               end
            end else begin
               cmd.eval = 1'b1;
               state_in = status.need_cross ? ST_MUL : ST_RUN;
            end
         end
         ST_CLOSE: begin
            cmd.close = 1'b1;
            state_in  = status.need_cross ? ST_MUL : ST_RUN;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (!status.div_busy) begin
               cmd.push_cross = 1'b1;
               state_in       = ST_RUN;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
      endcase
   end

`ifndef SYNTHESIS
   a_one_push_src: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.eval, cmd.push_cross}))
      else $error("two stack pushes in one cycle");
   a_mul_then_div: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |=> cmd.div_start)
      else $error("divide did not follow multiply");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> status.stack_empty)
      else $error("item accepted with work pending");
`endif

endmodule
